[hw/rtl/y2r_pkg.sv]
// Shared types, constants and chroma lookup tables for the YUYV to RGB888 pair converter.
// No dependencies; every other file of the block imports this package.
package y2r_pkg;

	localparam int CoefRv     = 1402;
	localparam int CoefGu     = 344;
	localparam int CoefGv     = 714;
	localparam int CoefBu     = 1772;
	localparam int PerMille   = 1000;
	localparam int ChromaZero = 128;
	localparam int ByteMax    = 255;
	localparam int LutDepth   = 256;

	// Chroma term range is -226..225, so 9 signed bits hold every entry.
	typedef logic signed [8:0] term_t;
	typedef term_t term_tbl_t [LutDepth];

	typedef struct packed {
		term_t dr;
		term_t gu;
		term_t gv;
		term_t db;
	} terms_t;

	// Elaboration-time table build: (c - 128) * coef / 1000, truncated toward zero.
	function automatic term_tbl_t build_term_tbl(input int coef);
		term_tbl_t t;
		for (int c = 0; c < LutDepth; c++) begin
			t[c] = term_t'(((c - ChromaZero) * coef) / PerMille);
		end
		return t;
	endfunction

	localparam term_tbl_t RvTbl = build_term_tbl(CoefRv);
	localparam term_tbl_t GuTbl = build_term_tbl(CoefGu);
	localparam term_tbl_t GvTbl = build_term_tbl(CoefGv);
	localparam term_tbl_t BuTbl = build_term_tbl(CoefBu);

endpackage

[hw/rtl/y2r_chroma.sv]
// Shared chroma stage: looks up the four per-mille chroma terms for one macropixel.
// Depends on y2r_pkg for the constant tables and the terms_t struct.
module y2r_chroma (
	input  logic [7:0]      u,
	input  logic [7:0]      v,
	output y2r_pkg::terms_t terms
);
	import y2r_pkg::*;

	always_comb begin
		terms.dr = RvTbl[v];
		terms.gu = GuTbl[u];
		terms.gv = GvTbl[v];
		terms.db = BuTbl[u];
	end

endmodule

[hw/rtl/y2r_lane.sv]
// One pixel lane: adds the shared chroma terms to a luma byte and saturates to RGB888.
// Depends on y2r_pkg for terms_t; two copies run side by side in the top level.
module y2r_lane (
	input  logic [7:0]      y,
	input  y2r_pkg::terms_t terms,
	output logic [7:0]      r,
	output logic [7:0]      g,
	output logic [7:0]      b
);
	import y2r_pkg::*;

	typedef logic signed [10:0] sum_t;

	sum_t y_s;
	sum_t dg;
	sum_t sum_r;
	sum_t sum_g;
	sum_t sum_b;

	function automatic logic [7:0] sat_byte(input sum_t s);
		if (s < sum_t'(0)) begin
			return 8'h00;
		end else if (s > sum_t'(ByteMax)) begin
			return 8'hFF;
		end
		return s[7:0];
	endfunction

	always_comb begin
		y_s   = $signed({3'b000, y});
		// each green term is truncated on its own before the sum
		dg    = -sum_t'(terms.gu) - sum_t'(terms.gv);
		sum_r = y_s + sum_t'(terms.dr);
		sum_g = y_s + dg;
		sum_b = y_s + sum_t'(terms.db);
		r     = sat_byte(sum_r);
		g     = sat_byte(sum_g);
		b     = sat_byte(sum_b);
	end

endmodule

[hw/rtl/yuyv_to_rgb24_pair.sv]
// YUYV macropixel to two RGB888 pixels (BT.601, per-mille weights), top level.
// Depends on y2r_pkg, y2r_chroma and y2r_lane.
//
// Usage:
//   Input channel (pair_valid / pair_ready) carries one YUYV macropixel per item:
//   luma_first, chroma_blue, luma_second, chroma_red and the last_pair flag.
//   Output channel (rgb_valid / rgb_ready) carries one item per input item: the
//   saturated RGB of both pixels and frame_end, a copy of last_pair.
// Pipeline: stage 1 registers the chroma table lookups and the luma bytes;
//   stage 2 is the output register fed by the two pixel lanes, which add the
//   shared terms and saturate.
// Throughput: one item per cycle while rgb_ready is high; both stages load
//   when the next stage is empty or draining; new items enter while results wait.
// Stall: when rgb_ready is low the output holds its item; stage 1 keeps one more
//   item and pair_ready drops only when both stages are full.
// Reset: arst_n clears both valid flags at once; the data registers are not reset.
module yuyv_to_rgb24_pair (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       pair_valid,
	output logic       pair_ready,
	input  logic [7:0] luma_first,
	input  logic [7:0] chroma_blue,
	input  logic [7:0] luma_second,
	input  logic [7:0] chroma_red,
	input  logic       last_pair,
	output logic       rgb_valid,
	input  logic       rgb_ready,
	output logic [7:0] red_first,
	output logic [7:0] green_first,
	output logic [7:0] blue_first,
	output logic [7:0] red_second,
	output logic [7:0] green_second,
	output logic [7:0] blue_second,
	output logic       frame_end
);
	import y2r_pkg::*;

	terms_t     terms;
	terms_t     terms_s1;
	logic [7:0] y0_s1;
	logic [7:0] y1_s1;
	logic       last_s1;
	logic       valid_s1;
	logic       valid_s2;
	logic       load_s1;
	logic       load_s2;

	logic [7:0] r0, g0, b0, r1, g1, b1;
	logic [7:0] r0_s2, g0_s2, b0_s2, r1_s2, g1_s2, b1_s2;
	logic       last_s2;

	y2r_chroma u_chroma (
		.u     (chroma_blue),
		.v     (chroma_red),
		.terms (terms)
	);

	y2r_lane u_lane_first (
		.y     (y0_s1),
		.terms (terms_s1),
		.r     (r0),
		.g     (g0),
		.b     (b0)
	);

	y2r_lane u_lane_second (
		.y     (y1_s1),
		.terms (terms_s1),
		.r     (r1),
		.g     (g1),
		.b     (b1)
	);

	always_comb begin
		load_s2    = valid_s1 && (!valid_s2 || rgb_ready);
		pair_ready = !valid_s1 || load_s2;
		load_s1    = pair_valid && pair_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (pair_ready) begin
				valid_s1 <= pair_valid;
			end
			if (!valid_s2 || rgb_ready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			terms_s1 <= terms;
			y0_s1    <= luma_first;
			y1_s1    <= luma_second;
			last_s1  <= last_pair;
		end
	end

	// merge both lanes into one output item
	always_ff @(posedge clk) begin
		if (load_s2) begin
			r0_s2   <= r0;
			g0_s2   <= g0;
			b0_s2   <= b0;
			r1_s2   <= r1;
			g1_s2   <= g1;
			b1_s2   <= b1;
			last_s2 <= last_s1;
		end
	end

	assign rgb_valid    = valid_s2;
	assign red_first    = r0_s2;
	assign green_first  = g0_s2;
	assign blue_first   = b0_s2;
	assign red_second   = r1_s2;
	assign green_second = g1_s2;
	assign blue_second  = b1_s2;
	assign frame_end    = last_s2;

`ifndef SYNTH
	a_ready_low_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!pair_ready |-> (valid_s1 && valid_s2 && !rgb_ready))
		else $error("pair_ready low while pipeline can advance");

	a_stage1_drains: assert property (@(posedge clk) disable iff (!arst_n)
		load_s2 |=> valid_s2)
		else $error("stage 1 item lost on transfer to output");

	a_flag_follows: assert property (@(posedge clk) disable iff (!arst_n)
		load_s2 |=> (frame_end == $past(last_s1)))
		else $error("frame_end does not follow the transferred item");

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		load_s1 |=> valid_s1)
		else $error("accepted item not held in stage 1");
`endif

endmodule
